// ===== rtl/core/min_tracking_stack_top_assert.svh =====
// Assertion macros for the minimum-tracking stack.
`ifndef MIN_TRACKING_STACK_TOP_ASSERT_SVH
`define MIN_TRACKING_STACK_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define MTS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define MTS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/core/mts_pkg.sv =====
// Shared types and constants for the minimum-tracking stack.
`timescale 1ns / 1ps

package mts_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned FILL_W          = 11;
  localparam int unsigned STACK_DEPTH_DEF = 1024;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Per-cycle command to one stack.
  typedef struct packed {
    logic push;
    logic pop;
  } mts_ctrl_t;

endpackage

// ===== rtl/core/mts_stack.sv =====
// One LIFO stack with a cached top and a read-ahead entry below it.
`timescale 1ns / 1ps

module mts_stack import mts_pkg::*; #(
  parameter int unsigned DEPTH = STACK_DEPTH_DEF,
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1),
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mts_ctrl_t         ctrl_i,
  input  logic [DATA_W-1:0] data_i,
  output logic [DATA_W-1:0] top_o,
  output logic [CNT_W-1:0]  count_o,
  output logic [DATA_W-1:0] nxt_top_o,
  output logic [CNT_W-1:0]  nxt_count_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]  count_q, count_d;
  logic [DATA_W-1:0] top_q, top_d;
  logic [DATA_W-1:0] below_q;
  logic [DATA_W-1:0] rd_q;
  logic              below_mem_q, below_mem_d;
  logic [DATA_W-1:0] below;
  logic [CNT_W-1:0]  rd_cnt;

  // After a pop the entry below the new top is fetched from memory; it is
  // ready in the next cycle, which is the earliest a following pop can need it.
  assign below  = below_mem_q ? rd_q : below_q;
  assign rd_cnt = count_q - CNT_W'(3);

  always_comb begin
    top_d       = top_q;
    count_d     = count_q;
    below_mem_d = below_mem_q;
    if (ctrl_i.push) begin
      top_d       = data_i;
      count_d     = count_q + CNT_W'(1);
      below_mem_d = 1'b0;
    end else if (ctrl_i.pop) begin
      top_d       = below;
      count_d     = count_q - CNT_W'(1);
      below_mem_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      below_mem_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      below_mem_q <= below_mem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (ctrl_i.push) begin
      below_q <= top_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[count_q[ADDR_W-1:0]] <= data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pop) begin
      rd_q <= mem[rd_cnt[ADDR_W-1:0]];
    end
  end

  assign top_o       = top_q;
  assign count_o     = count_q;
  assign nxt_top_o   = top_d;
  assign nxt_count_o = count_d;

endmodule

// ===== rtl/core/min_tracking_stack_top.sv =====
// Top level of the minimum-tracking stack with stream ports.
`timescale 1ns / 1ps
`include "min_tracking_stack_top_assert.svh"

// Signed 32-bit LIFO stack that reports its top, its minimum, an empty flag,
// the fill count and a status for every beat. Each input beat is a push or a
// pop; a push on a full stack reports overflow and a pop on an empty stack
// reports underflow, and neither changes the contents. The block takes one
// beat per cycle while its second result register is empty. A taken beat is
// held in the input register, and its result is then registered in the
// result buffer. The tops of both the value stack and the minimum stack are
// held in registers, and each pop reads the next entry from memory ahead of
// time, so back-to-back pops do not stall. A second result register lets one
// more result be stored while the output is stalled. The stores need no
// clearing after reset.
module min_tracking_stack_top import mts_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // push_value[31:0]
  input  logic        s_axis_tuser,   // operation[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // top_value[31:0], min_value[63:32],
                                      // is_empty[64], fill_count[75:65], zero[79:76]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  // Input register
  logic              in_v_q;
  logic              in_op_q;
  logic [DATA_W-1:0] in_val_q;

  // Result registers
  logic              out_v_q, skid_v_q;
  logic [79:0]       out_data_q, skid_data_q;
  logic [1:0]        out_st_q, skid_st_q;

  logic              advance, out_pop;

  mts_ctrl_t         v_ctrl, m_ctrl;
  logic [DATA_W-1:0] v_top, v_nxt_top, m_top, m_nxt_top;
  logic [CNT_W-1:0]  v_cnt, v_nxt_cnt, m_cnt, m_nxt_cnt;

  logic              v_full, v_empty, m_take;
  status_e           st;
  logic [DATA_W-1:0] res_top, res_min;
  logic              res_empty;
  logic [79:0]       res_data;

  assign advance       = in_v_q && !skid_v_q;
  assign out_pop       = out_v_q && m_axis_tready;
  assign s_axis_tready = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_v_q <= 1'b1;
    end else if (advance) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q  <= s_axis_tuser;
      in_val_q <= s_axis_tdata;
    end
  end

  // Stack decisions
  assign v_full  = (v_cnt == CNT_W'(STACK_DEPTH));
  assign v_empty = (v_cnt == '0);
  assign m_take  = (m_cnt == '0) || ($signed(m_top) >= $signed(in_val_q));

  always_comb begin
    v_ctrl = '0;
    m_ctrl = '0;
    st     = ST_OK;
    if (advance) begin
      if (in_op_q == OP_PUSH) begin
        if (v_full) begin
          st = ST_OVERFLOW;
        end else begin
          v_ctrl.push = 1'b1;
          m_ctrl.push = m_take && (m_cnt != CNT_W'(STACK_DEPTH));
        end
      end else begin
        if (v_empty) begin
          st = ST_UNDERFLOW;
        end else begin
          v_ctrl.pop = 1'b1;
          m_ctrl.pop = (m_cnt != '0) && (v_top == m_top);
        end
      end
    end
  end

  mts_stack #(.DEPTH(STACK_DEPTH)) u_value_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (v_ctrl),
    .data_i      (in_val_q),
    .top_o       (v_top),
    .count_o     (v_cnt),
    .nxt_top_o   (v_nxt_top),
    .nxt_count_o (v_nxt_cnt)
  );

  mts_stack #(.DEPTH(STACK_DEPTH)) u_minimum_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (m_ctrl),
    .data_i      (in_val_q),
    .top_o       (m_top),
    .count_o     (m_cnt),
    .nxt_top_o   (m_nxt_top),
    .nxt_count_o (m_nxt_cnt)
  );

  assign res_empty = (v_nxt_cnt == '0);
  assign res_top   = res_empty ? '0 : v_nxt_top;
  assign res_min   = (res_empty || (m_nxt_cnt == '0)) ? '0 : m_nxt_top;
  assign res_data  = {4'b0000, FILL_W'(v_nxt_cnt), res_empty, res_min, res_top};

  // Two-deep result buffer: the second register only fills while the
  // output is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (advance) begin
      if (out_v_q && !out_pop) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (out_v_q && !out_pop) begin
        skid_data_q <= res_data;
        skid_st_q   <= st;
      end else begin
        out_data_q <= res_data;
        out_st_q   <= st;
      end
    end else if (out_pop && skid_v_q) begin
      out_data_q <= skid_data_q;
      out_st_q   <= skid_st_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_st_q;

  `MTS_ASSERT_ALWAYS(a_min_not_deeper, m_cnt <= v_cnt, "minimum stack too deep")
  `MTS_ASSERT_ALWAYS(a_min_present, (v_cnt == '0) || (m_cnt != '0), "minimum stack empty")
  `MTS_ASSERT_ALWAYS(a_skid_order, !skid_v_q || out_v_q, "second result without a first")
  `MTS_ASSERT_NEXT(a_push_count, v_ctrl.push, v_cnt == $past(v_cnt) + CNT_W'(1), "push lost")

endmodule
